FILE: sv/memory_tiered_least_loaded_dispatch_unit_defines.svh
`ifndef MEMORY_TIERED_LEAST_LOADED_DISPATCH_UNIT_DEFINES_SVH
`define MEMORY_TIERED_LEAST_LOADED_DISPATCH_UNIT_DEFINES_SVH

// cond must never hold while out of reset
`define MTLD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante in one cycle implies cons in the next
`define MTLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mtld_pkg.sv
package mtld_pkg;

  localparam int NumProc = 5;
  localparam int ProcW   = $clog2(NumProc);
  localparam int MaxJobs = 256;
  localparam int CountW  = 9;
  localparam int LoadW   = 32;
  localparam int CyclesW = 24;
  localparam int MemW    = 16;
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam int CountCapInt = (MaxJobs < 511) ? MaxJobs : 511;
  localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);
  localparam logic [ProcW-1:0]  LastProc = ProcW'(NumProc - 1);

  localparam logic [1:0]  CfgHighThr   = 2'd0;
  localparam logic [1:0]  CfgMidThr    = 2'd1;
  localparam logic [1:0]  CfgMidFirst  = 2'd2;

  localparam logic [15:0] HighThrReset  = 16'd2000;
  localparam logic [15:0] MidThrReset   = 16'd1000;
  localparam logic [2:0]  MidFirstReset = 3'd2;

  typedef enum logic [1:0] {
    TierLow  = 2'd0,
    TierMid  = 2'd1,
    TierHigh = 2'd2
  } tier_e;

  typedef struct packed {
    logic [CyclesW-1:0] job_cycles;
    logic [MemW-1:0]    job_memory;
  } job_in_t;

  typedef struct packed {
    logic [2:0]        assigned_processor;
    tier_e             memory_tier;
    logic [LoadW-1:0]  new_load;
    logic [CountW-1:0] jobs_on_processor;
  } job_out_t;

  typedef struct packed {
    logic [CyclesW-1:0] cycles;
    tier_e              tier;
    logic [ProcW-1:0]   first;
  } task_t;

endpackage

FILE: sv/mtld_front.sv
module mtld_front
  import mtld_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  job_in_t       in_item_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output task_t         push_data_o
);

  logic [15:0] high_thr_q;
  logic [15:0] mid_thr_q;
  logic [2:0]  mid_first_q;
  logic [ProcW-1:0] mid_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q  <= HighThrReset;
      mid_thr_q   <= MidThrReset;
      mid_first_q <= MidFirstReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHighThr:  high_thr_q  <= cfg_wdata_i;
        CfgMidThr:   mid_thr_q   <= cfg_wdata_i;
        CfgMidFirst: mid_first_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign mid_clamped = (32'(mid_first_q) >= NumProc) ? LastProc : ProcW'(mid_first_q);

  always_comb begin
    push_data_o.cycles = in_item_i.job_cycles;
    if (in_item_i.job_memory > high_thr_q) begin
      push_data_o.tier  = TierHigh;
      push_data_o.first = LastProc;
    end else if (in_item_i.job_memory > mid_thr_q) begin
      push_data_o.tier  = TierMid;
      push_data_o.first = mid_clamped;
    end else begin
      push_data_o.tier  = TierLow;
      push_data_o.first = '0;
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

FILE: sv/mtld_queue.sv
module mtld_queue
  import mtld_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  task_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output task_t pop_data_o
);

  task_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/mtld_back.sv
module mtld_back
  import mtld_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  task_t    pop_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output job_out_t out_item_o
);

  logic [LoadW-1:0]  load_q  [NumProc];
  logic [CountW-1:0] count_q [NumProc];
  logic              out_valid_q;
  job_out_t          out_item_q;

  logic [ProcW-1:0]  best;
  logic [LoadW-1:0]  best_load;
  logic [LoadW:0]    sum;
  logic [LoadW-1:0]  load_new;
  logic [CountW-1:0] count_new;
  logic              pop;

  // least-loaded search from the first allowed index, lowest index wins ties
  always_comb begin
    best      = pop_data_i.first;
    best_load = '1;
    for (int k = 0; k < NumProc; k++) begin
      if (ProcW'(k) >= pop_data_i.first && load_q[k] < best_load) begin
        best      = ProcW'(k);
        best_load = load_q[k];
      end
    end
  end

  assign sum       = {1'b0, load_q[best]} + (LoadW+1)'(pop_data_i.cycles);
  assign load_new  = sum[LoadW] ? '1 : sum[LoadW-1:0];
  assign count_new = (count_q[best] < CountCap) ? count_q[best] + 1'b1 : count_q[best];

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumProc; k++) begin
        load_q[k]  <= '0;
        count_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        load_q[best]  <= load_new;
        count_q[best] <= count_new;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_item_q.assigned_processor <= 3'(best);
      out_item_q.memory_tier        <= pop_data_i.tier;
      out_item_q.new_load           <= load_new;
      out_item_q.jobs_on_processor  <= count_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: sv/memory_tiered_least_loaded_dispatch_unit.sv
// Places one job per clock, when not stalled, on the least-loaded of five processors, by
// memory tier: above the high threshold a job goes to the last processor, above the mid
// threshold to the least-loaded from the configured first index, else to the least-loaded
// overall, lowest index on ties. Loads and job counts saturate. The job rate is set by the
// combinational search and add and the registered write-back of the load table in the back
// stage; a taken job is registered in the queue, then in the output register. A two-entry
// queue sits between the classifying front and the back stage. Registers: 0 high threshold,
// 1 mid threshold, 2 first processor for mid jobs; write them only while no job is in flight.
module memory_tiered_least_loaded_dispatch_unit
  import mtld_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  job_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output job_out_t out_item_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  task_t push_data, pop_data;

  mtld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mtld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mtld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: sv/mtld_checker.sv
`include "memory_tiered_least_loaded_dispatch_unit_defines.svh"

module mtld_checker
  import mtld_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input job_out_t    out_item_o
);

  `MTLD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_item_o),
    "stalled result beat changed")
  `MTLD_ASSERT_NEVER(a_proc_range, clk_i, rst_ni,
    out_valid_o && (32'(out_item_o.assigned_processor) >= NumProc),
    "processor index out of range")
  `MTLD_ASSERT_NEVER(a_high_last, clk_i, rst_ni,
    out_valid_o && out_item_o.memory_tier == TierHigh &&
    out_item_o.assigned_processor != 3'(LastProc),
    "high tier job not on last processor")
  `MTLD_ASSERT_NEVER(a_count_nonzero, clk_i, rst_ni,
    out_valid_o && out_item_o.jobs_on_processor == '0,
    "result beat with zero job count")
  `MTLD_ASSERT_NEXT(a_result_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o && !out_valid_o,
    ##1 out_valid_o,
    "no result two cycles after job beat")

endmodule

bind memory_tiered_least_loaded_dispatch_unit mtld_checker u_mtld_checker (.*);
